>>> src/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define CTS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cts: assertion failed");
// Checked at every clock edge, reset included.
`define CTS_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("cts: invariant violated");
`else
`define CTS_ASSERT(label, prop)
`define CTS_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> src/cts_pkg.sv
// Types and constants of the cooperative task scheduler.
// Used by cts_cell, cts_head and cooperative_task_scheduler; depends on nothing.
package cts_pkg;

	localparam int OP_W        = 2;
	localparam int DELAY_W     = 16;
	localparam int PEND_W      = 8;
	localparam int SLOT_FIELD_W = 5;
	localparam int KIND_W      = 2;
	localparam int MAX_RESULTS = 32;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [PEND_W-1:0] PENDING_MAX = 8'd255;

	// Operation codes of an input transaction.
	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_TICK     = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_DELETE   = 2'd3
	} op_t;

	// Kinds of result transaction.
	typedef enum logic [KIND_W-1:0] {
		KIND_DISPATCHED = 2'd0,
		KIND_ADDED      = 2'd1,
		KIND_REFUSED    = 2'd2
	} kind_t;

	// Contents of one task slot.
	typedef struct packed {
		logic               valid;
		logic [DELAY_W-1:0] delay;
		logic [DELAY_W-1:0] period;
		logic [PEND_W-1:0]  pending;
	} slot_t;

	// Walk control handed to the head unit.
	typedef struct packed {
		logic tick;
		logic dispatch;
	} head_ctl_t;

endpackage

>>> src/cts_cell.sv
// One task slot cell of the scheduler ring.
// Depends on cts_pkg for the slot type.
module cts_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  cts_pkg::slot_t  shift_in,
	input  logic            wr_en,
	input  cts_pkg::slot_t  wr_data,
	output cts_pkg::slot_t  slot_q
);

	// A direct write happens only while the ring is at rest; otherwise the
	// cell takes its neighbour's contents on every walk step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (wr_en) begin
			slot_q <= wr_data;
		end else if (shift_en) begin
			slot_q <= shift_in;
		end
	end

endmodule

>>> src/cts_head.sv
// Update unit at the head of the slot ring: applies a tick or a dispatch
// to the slot passing through. Depends on cts_pkg.
module cts_head (
	input  cts_pkg::head_ctl_t ctl,
	input  cts_pkg::slot_t     slot_in,
	output cts_pkg::slot_t     slot_out,
	output logic               hit
);

	// Tick counts the delay down or, when due, raises the pending count (saturating)
	// and reloads a periodic slot; dispatch takes one pending run and retires a one-shot slot.
	always_comb begin
		slot_out = slot_in;
		hit      = 1'b0;
		if (ctl.tick) begin
			if (slot_in.valid) begin
				if (slot_in.delay == '0) begin
					if (slot_in.pending != cts_pkg::PENDING_MAX) begin
						slot_out.pending = slot_in.pending + 8'd1;
					end
					if (slot_in.period != '0) begin
						slot_out.delay = slot_in.period;
					end
				end else begin
					slot_out.delay = slot_in.delay - 16'd1;
				end
			end
		end else if (ctl.dispatch && slot_in.pending != '0) begin
			hit = 1'b1;
			slot_out.pending = slot_in.pending - 8'd1;
			if (slot_in.period == '0) begin
				slot_out = '0;
			end
		end
	end

endmodule

>>> src/cooperative_task_scheduler.sv
// Cooperative time-triggered task scheduler, top level.
// Depends on cts_pkg, cts_cell, cts_head and assert_macros.svh.
//
// Input channel (in_valid, in_stall) carries operation, start_delay,
// repeat_period and slot_index; output channel (out_valid, out_stall)
// carries task_slot, result_kind and last. A transaction moves on an edge
// where valid is high and stall is low.
// Add and delete complete at the accepting edge, which registers an add's single
// result in the output register. Tick and dispatch rotate the slot ring once
// through the head unit, one slot per cycle while no held result waits on a
// stalled output, and the input stays stalled for the whole walk; a dispatch that
// found work then passes through ST_FLUSH to hand over its final result,
// marked by last. The input is stalled until the current operation is
// complete and the output register can take a new result.
// When the receiver stalls, the output register holds its result and the
// ring pauses at the next slot that must report, so nothing is lost.
// Dispatch reports at most 32 slots per transaction; later pending slots
// keep their runs. Reset empties all slots and hands out slot 1 next.
// Slots are never reused, and an add to a full table is refused.
`include "assert_macros.svh"

module cooperative_task_scheduler #(
	parameter int TASK_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic [4:0]  slot_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  task_slot,
	output logic [1:0]  result_kind,
	output logic        last
);

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int NF_W   = $clog2(TASK_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t                                 state_q;
	logic                                   is_disp_q;
	logic [SLOT_W-1:0]                      walk_q;
	logic [cts_pkg::RES_W-1:0]              nres_q;
	logic                                   hold_valid_q;
	logic [SLOT_W-1:0]                      hold_slot_q;
	logic [NF_W-1:0]                        next_free_q;
	logic                                   out_valid_q;
	logic [cts_pkg::SLOT_FIELD_W-1:0]       out_slot_q;
	cts_pkg::kind_t                         out_kind_q;
	logic                                   out_last_q;

	cts_pkg::slot_t    cell_q [TASK_SLOTS];
	cts_pkg::slot_t    head_out;
	cts_pkg::head_ctl_t head_ctl;
	cts_pkg::slot_t    wr_data;
	cts_pkg::op_t      op;
	logic              head_hit;
	logic              out_free;
	logic              accept;
	logic              table_full;
	logic              walk_end;
	logic              shift_en;
	logic              push_hold;

	assign op         = cts_pkg::op_t'(operation);
	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = !(state_q == ST_IDLE && out_free);
	assign accept     = in_valid && !in_stall;
	assign table_full = next_free_q >= NF_W'(TASK_SLOTS);
	assign walk_end   = walk_q == SLOT_W'(TASK_SLOTS - 1);

	// Head unit works on the slot at cell zero during a walk.
	assign head_ctl.tick     = (state_q == ST_WALK) && !is_disp_q;
	assign head_ctl.dispatch = (state_q == ST_WALK) && is_disp_q
		&& (nres_q < cts_pkg::RES_W'(cts_pkg::MAX_RESULTS));

	cts_head u_head (
		.ctl      (head_ctl),
		.slot_in  (cell_q[0]),
		.slot_out (head_out),
		.hit      (head_hit)
	);

	// A hit with an earlier result still held must first pass that result on.
	assign push_hold = head_hit && hold_valid_q;
	assign shift_en  = (state_q == ST_WALK) && (!push_hold || out_free);

	// An add fills a fresh slot with no pending runs; a delete clears it.
	always_comb begin
		wr_data = '0;
		if (op == cts_pkg::OP_ADD) begin
			wr_data.valid  = 1'b1;
			wr_data.delay  = start_delay;
			wr_data.period = repeat_period;
		end
	end

	// The ring of slot cells; the head result re-enters at the far end.
	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
		logic           wr_en;
		cts_pkg::slot_t shift_in;

		assign wr_en = accept && (
			(op == cts_pkg::OP_ADD && !table_full && 32'(next_free_q) == i) ||
			(op == cts_pkg::OP_DELETE && 32'(slot_index) == i));

		if (i == TASK_SLOTS - 1) begin : g_tail
			assign shift_in = head_out;
		end else begin : g_link
			assign shift_in = cell_q[i + 1];
		end

		cts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.shift_in (shift_in),
			.wr_en    (wr_en),
			.wr_data  (wr_data),
			.slot_q   (cell_q[i])
		);
	end

	// Sequencer, slot allocation and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			is_disp_q    <= 1'b0;
			walk_q       <= '0;
			nres_q       <= '0;
			hold_valid_q <= 1'b0;
			hold_slot_q  <= '0;
			next_free_q  <= NF_W'(1);
			out_valid_q  <= 1'b0;
			out_slot_q   <= '0;
			out_kind_q   <= cts_pkg::KIND_DISPATCHED;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						walk_q <= '0;
						nres_q <= '0;
						unique case (op)
							cts_pkg::OP_ADD: begin
								out_valid_q <= 1'b1;
								out_last_q  <= 1'b1;
								if (table_full) begin
									out_slot_q <= '0;
									out_kind_q <= cts_pkg::KIND_REFUSED;
								end else begin
									out_slot_q  <= cts_pkg::SLOT_FIELD_W'(next_free_q);
									out_kind_q  <= cts_pkg::KIND_ADDED;
									next_free_q <= next_free_q + NF_W'(1);
								end
							end
							cts_pkg::OP_TICK: begin
								state_q   <= ST_WALK;
								is_disp_q <= 1'b0;
							end
							cts_pkg::OP_DISPATCH: begin
								state_q   <= ST_WALK;
								is_disp_q <= 1'b1;
							end
							cts_pkg::OP_DELETE: begin
								state_q <= ST_IDLE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (shift_en) begin
						if (head_hit) begin
							if (hold_valid_q) begin
								out_valid_q <= 1'b1;
								out_slot_q  <= cts_pkg::SLOT_FIELD_W'(hold_slot_q);
								out_kind_q  <= cts_pkg::KIND_DISPATCHED;
								out_last_q  <= 1'b0;
							end
							hold_valid_q <= 1'b1;
							hold_slot_q  <= walk_q;
							nres_q       <= nres_q + cts_pkg::RES_W'(1);
						end
						walk_q <= walk_q + SLOT_W'(1);
						if (walk_end) begin
							walk_q  <= '0;
							state_q <= (head_hit || hold_valid_q) ? ST_FLUSH : ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_slot_q   <= cts_pkg::SLOT_FIELD_W'(hold_slot_q);
						out_kind_q   <= cts_pkg::KIND_DISPATCHED;
						out_last_q   <= 1'b1;
						hold_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign task_slot   = out_slot_q;
	assign result_kind = out_kind_q;
	assign last        = out_last_q;

	// A held dispatch result never outlives its walk.
	`CTS_ASSERT_ALWAYS(a_hold_only_busy, hold_valid_q |-> state_q != ST_IDLE)
	// A dispatch never reports more slots than the result limit.
	`CTS_ASSERT(a_result_limit, nres_q <= cts_pkg::RES_W'(cts_pkg::MAX_RESULTS))
	// Slots are handed out in rising order and never taken back.
	`CTS_ASSERT(a_alloc_monotonic, 1'b1 |=> next_free_q >= $past(next_free_q))
	// The ring pauses only while a finished result is blocked at the output.
	`CTS_ASSERT(a_walk_pause, (state_q == ST_WALK && !shift_en) |-> (out_valid_q && out_stall))

endmodule

>>> tb/cts_checker.sv
// Scoreboard for the cooperative task scheduler: watches both channels, predicts results.
// It keeps its own copy of the slot table and compares each result transaction in order.
// Depends on cts_pkg.
module cts_checker #(
	parameter int TASK_SLOTS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [cts_pkg::OP_W-1:0]         operation,
	input  logic [cts_pkg::DELAY_W-1:0]      start_delay,
	input  logic [cts_pkg::DELAY_W-1:0]      repeat_period,
	input  logic [cts_pkg::SLOT_FIELD_W-1:0] slot_index,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [cts_pkg::SLOT_FIELD_W-1:0] task_slot,
	input  logic [cts_pkg::KIND_W-1:0]       result_kind,
	input  logic                             last,
	output int                               fail_count,
	output int                               owed_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result transaction as the scheduler should present it.
	typedef struct packed {
		logic [cts_pkg::SLOT_FIELD_W-1:0] slot;
		cts_pkg::kind_t                   kind;
		logic                             fin;
	} sched_result_t;

	cts_pkg::slot_t slot_tab [TASK_SLOTS];
	logic [5:0]     next_slot;
	sched_result_t  owed_results [$];
	sched_result_t  want;
	int             mismatches;

	function automatic sched_result_t make_result(int slot, cts_pkg::kind_t kind, logic fin);
		sched_result_t r;
		r.slot = cts_pkg::SLOT_FIELD_W'(slot);
		r.kind = kind;
		r.fin  = fin;
		return r;
	endfunction

	task automatic clear_entry(int s);
		slot_tab[s] = '0;
	endtask

	// Applies one input transaction to the shadow table and queues the results it owes.
	task automatic advance_schedule(cts_pkg::op_t op, logic [cts_pkg::DELAY_W-1:0] dly,
			logic [cts_pkg::DELAY_W-1:0] per, logic [cts_pkg::SLOT_FIELD_W-1:0] idx);
		sched_result_t held;
		logic          have_held;
		int            n;
		int            s;
		held      = '0;
		have_held = 1'b0;
		n         = 0;
		case (op)
			cts_pkg::OP_ADD: begin
				if (next_slot >= TASK_SLOTS) begin
					// A full table refuses the add and nothing changes.
					owed_results.push_back(make_result(0, cts_pkg::KIND_REFUSED, 1'b1));
				end else begin
					slot_tab[next_slot].valid   = 1'b1;
					slot_tab[next_slot].delay   = dly;
					slot_tab[next_slot].period  = per;
					slot_tab[next_slot].pending = '0;
					owed_results.push_back(make_result(next_slot, cts_pkg::KIND_ADDED, 1'b1));
					next_slot = next_slot + 1'b1;
				end
			end
			cts_pkg::OP_TICK: begin
				for (s = 0; s < TASK_SLOTS; s++) begin
					if (slot_tab[s].valid) begin
						if (slot_tab[s].delay == '0) begin
							// Due: one more run, saturating, and reload if periodic.
							if (slot_tab[s].pending < cts_pkg::PENDING_MAX)
								slot_tab[s].pending = slot_tab[s].pending + 1'b1;
							if (slot_tab[s].period != '0)
								slot_tab[s].delay = slot_tab[s].period;
						end else begin
							slot_tab[s].delay = slot_tab[s].delay - 1'b1;
						end
					end
				end
			end
			cts_pkg::OP_DISPATCH: begin
				// Each result is held back one step so that the final one can carry last.
				for (s = 0; s < TASK_SLOTS && n < cts_pkg::MAX_RESULTS; s++) begin
					if (slot_tab[s].pending != '0) begin
						slot_tab[s].pending = slot_tab[s].pending - 1'b1;
						if (have_held)
							owed_results.push_back(held);
						held      = make_result(s, cts_pkg::KIND_DISPATCHED, 1'b0);
						have_held = 1'b1;
						n++;
						if (slot_tab[s].period == '0)
							clear_entry(s);
					end
				end
				if (have_held) begin
					held.fin = 1'b1;
					owed_results.push_back(held);
				end
			end
			cts_pkg::OP_DELETE: begin
				if (idx < TASK_SLOTS)
					clear_entry(idx);
			end
			default: begin
			end
		endcase
	endtask

	// Results are compared before the same edge's input is applied, as they belong to older work.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < TASK_SLOTS; s++)
				clear_entry(s);
			next_slot = 6'd1;
			owed_results.delete();
			mismatches = 0;
			fail_count <= 0;
			owed_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$error("task_slot %0d kind %0d: result transaction with nothing owed",
						task_slot, result_kind);
				end else begin
					want = owed_results.pop_front();
					if (task_slot !== want.slot) begin
						mismatches++;
						$error("task_slot: expected %0d, actual %0d", want.slot, task_slot);
					end
					if (result_kind !== want.kind) begin
						mismatches++;
						$error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
					end
					if (last !== want.fin) begin
						mismatches++;
						$error("last: expected %0d, actual %0d", want.fin, last);
					end
				end
			end
			if (in_valid && !in_stall)
				advance_schedule(cts_pkg::op_t'(operation), start_delay, repeat_period,
					slot_index);
			fail_count <= mismatches;
			owed_count <= owed_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the scheduler testbench: clock, reset, stimulus, receiver stalls and the verdict.
// Depends on cts_pkg, cts_checker and the cooperative_task_scheduler RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TASK_SLOTS   = 32;
	localparam int DRAIN_CYCLES = TASK_SLOTS + 8;
	// Far above the slowest run: about 480 transactions of a full walk plus stalled results.
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic [1:0]  operation     = cts_pkg::OP_ADD;
	logic [15:0] start_delay   = '0;
	logic [15:0] repeat_period = '0;
	logic [4:0]  slot_index    = '0;
	logic        out_stall     = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [4:0]  task_slot;
	logic [1:0]  result_kind;
	logic        last;
	bit          steady        = 1'b0;
	int          fail_count;
	int          owed_count;
	int unsigned cycle_count   = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cooperative_task_scheduler #(
		.TASK_SLOTS(TASK_SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.start_delay  (start_delay),
		.repeat_period(repeat_period),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.task_slot    (task_slot),
		.result_kind  (result_kind),
		.last         (last)
	);

	cts_checker #(
		.TASK_SLOTS(TASK_SLOTS)
	) sched_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.start_delay  (start_delay),
		.repeat_period(repeat_period),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.task_slot    (task_slot),
		.result_kind  (result_kind),
		.last         (last),
		.fail_count   (fail_count),
		.owed_count   (owed_count)
	);

	// The receiver stalls at random, except during the steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 29);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Presents one transaction after a random gap and returns at the edge that takes it.
	task automatic send_item(cts_pkg::op_t op, logic [15:0] dly, logic [15:0] per,
			logic [4:0] idx);
		while (!steady && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		start_delay   <= dly;
		repeat_period <= per;
		slot_index    <= idx;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Mostly short countdowns so that slots fall due often; now and then the far extremes.
	function automatic logic [15:0] pick_ticks(int zero_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < zero_pct)
			return '0;
		else if (roll < 70)
			return 16'($urandom_range(1, 6));
		else if (roll < 85)
			return 16'($urandom_range(7, 40));
		else if (roll < 95)
			return 16'($urandom);
		else
			return 16'hFFFF;
	endfunction

	// One random transaction; fields an operation ignores still carry random bits.
	task automatic send_random(int add_pct);
		int           roll;
		cts_pkg::op_t op;
		logic [15:0]  dly;
		logic [15:0]  per;
		roll = $urandom_range(0, 99);
		if (roll < add_pct) begin
			op = cts_pkg::OP_ADD;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 52)
				op = cts_pkg::OP_TICK;
			else if (roll < 92)
				op = cts_pkg::OP_DISPATCH;
			else
				op = cts_pkg::OP_DELETE;
		end
		if (op == cts_pkg::OP_ADD) begin
			dly = pick_ticks(15);
			per = pick_ticks(40);
		end else begin
			dly = 16'($urandom);
			per = 16'($urandom);
		end
		send_item(op, dly, per, 5'($urandom_range(0, 31)));
	endtask

	// Waits until every owed result has been taken; the checker's count is registered, so the task first lets it update.
	task automatic wait_results_drained();
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty table, field extremes, one-shot left waiting, deletes of odd slots.
		send_item(cts_pkg::OP_DISPATCH, 16'hFFFF, 16'hFFFF, 5'd31);
		send_item(cts_pkg::OP_TICK, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_DELETE, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_ADD, 16'h0000, 16'h0000, 5'd31);
		send_item(cts_pkg::OP_ADD, 16'h0000, 16'h0001, 5'd0);
		send_item(cts_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 5'd0);
		send_item(cts_pkg::OP_ADD, 16'h0002, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_ADD, 16'h0001, 16'h0003, 5'd0);
		repeat (3) send_item(cts_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 5'd31);
		send_item(cts_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_DELETE, 16'h0000, 16'h0000, 5'd2);
		send_item(cts_pkg::OP_DELETE, 16'hFFFF, 16'hFFFF, 5'd31);
		send_item(cts_pkg::OP_TICK, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_TICK, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_ADD, 16'hA5A5, 16'h5A5A, 5'd31);
		send_item(cts_pkg::OP_DELETE, 16'h0000, 16'h0000, 5'd6);
		send_item(cts_pkg::OP_ADD, 16'h0000, 16'hFFFF, 5'd0);
		send_item(cts_pkg::OP_TICK, 16'h0000, 16'h0000, 5'd0);
		send_item(cts_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 5'd0);

		// Random mix with a stretch where neither side idles.
		for (int i = 0; i < 150; i++) begin
			if (i == 60)
				steady <= 1'b1;
			if (i == 110)
				steady <= 1'b0;
			send_random(8);
		end

		// Hold off until all results are in, then drive a waiting one-shot into saturation.
		in_valid <= 1'b0;
		wait_results_drained();
		send_item(cts_pkg::OP_ADD, 16'h0000, 16'h0000, 5'd0);
		repeat (268) send_item(cts_pkg::OP_TICK, 16'($urandom), 16'($urandom), 5'($urandom));
		send_item(cts_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 5'd0);

		// Add-heavy tail so that the table fills and adds are refused.
		for (int i = 0; i < 40; i++)
			send_random(35);

		in_valid <= 1'b0;
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && owed_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

>>> cooperative_task_scheduler.f
+incdir+src
src/cts_pkg.sv
src/cts_cell.sv
src/cts_head.sv
src/cooperative_task_scheduler.sv
tb/cts_checker.sv
tb/tb_top.sv
